/* rtl/core/bfa_pkg.sv */
package bfa_pkg;

  localparam int PHASE_BITS  = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int SUM_W       = 48;
  localparam int WSUM_W      = 32;
  localparam int TERM_W      = 33;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // sine polynomial coefficients, q2.30
  localparam logic [31:0] POLY_A = 32'd1686629713;
  localparam logic [31:0] POLY_B = 32'd693598668;
  localparam logic [31:0] POLY_C = 32'd85569306;
  localparam logic [31:0] POLY_D = 32'd5026995;
  localparam logic [31:0] POLY_E = 32'd172273;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic [15:0] phase;
    logic [15:0] weight;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [16:0] bunching;
    logic        zero_weight;
  } out_item_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] cos_term;
    logic signed [TERM_W-1:0] sin_term;
    logic [WEIGHT_BITS-1:0]   weight;
    logic                     last;
  } q_item_t;

  typedef enum logic [2:0] {
    BK_ACC,
    BK_LOAD,
    BK_MUL,
    BK_SQRT,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

/* rtl/core/bunching_factor_accumulator_top.sv */
// bunching factor accumulator: particles (phase as a fraction of a turn, unsigned
// weight) stream in at one per cycle; an eight-stage front pipeline evaluates sine and
// cosine by polynomial and forms the weighted terms, which a four-entry queue hands to
// the back end for accumulation. on the transaction marked last the back end runs a
// sequencer: eight 24x24 partial products for the squared magnitude, a 49-bit square
// root found one bit a cycle, then an 18-bit restoring division for the slice result.
// during that time no particle is taken from the queue, so the input stalls once the
// queue and front pipeline fill; otherwise one particle is taken every cycle. a result
// of zero total weight is reported as 0 with zero_weight set, and results are clamped
// to 1.0 (65536 in q1.16). the result sits in an output register, so particles of the
// next slice are accumulated while it waits to be taken
module bunching_factor_accumulator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bfa_pkg::out_item_t out_data
);
  import bfa_pkg::*;

  // front to queue
  logic    fq_valid;
  logic    fq_ready;
  q_item_t fq_data;

  // queue to back end
  logic    qb_valid;
  logic    qb_ready;
  q_item_t qb_data;

  bfa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  bfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  bfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a zero-weight slice always reports zero
  a_zero_weight : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_weight |-> out_data.bunching == '0)
    else $error("zero-weight result not zero");

  // result never above 1.0
  a_clamp : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bunching <= ONE_Q16)
    else $error("bunching above 1.0");

  // nothing leaves the queue while the back end is busy with a slice result
  a_no_pop_busy : assert property (@(posedge clk) disable iff (rst)
    qb_valid && qb_ready && qb_data.last |=> !qb_ready)
    else $error("queue popped during result sequence");

  // no result straight out of reset
  a_reset_quiet : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

/* rtl/core/bfa_front.sv */
module bfa_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfa_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output bfa_pkg::q_item_t  q_data
);
  import bfa_pkg::*;

  typedef struct packed {
    logic               neg;
    logic [16:0]        x;
    logic [16:0]        x2;
    logic [31:0]        p;
    logic signed [16:0] c;
  } lane_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] w;
    logic                   last;
    lane_t [1:0]            ln;   // 1 cosine, 0 sine
  } stage_t;

  stage_t     stg [0:6];
  logic [7:0] vld;
  logic       adv;
  q_item_t    term;

  function automatic lane_t lane_init(logic [31:0] ang);
    lane_t r;
    r     = '0;
    r.neg = ang[31];
    r.x   = ang[30] ? (17'd65536 - {1'b0, ang[29:14]}) : {1'b0, ang[29:14]};
    return r;
  endfunction

  function automatic logic [31:0] poly_step(logic [31:0] k, logic [31:0] p, logic [16:0] x2);
    logic [48:0] prod;
    prod = p * x2;
    return k - prod[47:16];
  endfunction

  function automatic logic signed [16:0] round_q15(logic [31:0] p, logic [16:0] x, logic neg);
    logic [48:0] prod;
    logic [32:0] v;
    logic [16:0] mag;
    prod = p * x;
    v    = {1'b0, prod[47:16]} + 33'd16384;
    mag  = (v[32:15] > 18'd32768) ? 17'd32768 : v[31:15];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  logic [31:0] ang_s;
  logic [31:0] ang_c;

  assign ang_s = {in_data.phase[PHASE_BITS-1:0], {(32-PHASE_BITS){1'b0}}};
  assign ang_c = ang_s + 32'h4000_0000;

  assign adv      = !vld[7] || q_ready;
  assign in_ready = adv;
  assign q_valid  = vld[7];
  assign q_data   = term;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].w     <= in_data.weight[WEIGHT_BITS-1:0];
      stg[0].last  <= in_data.last;
      stg[0].ln[1] <= lane_init(ang_c);
      stg[0].ln[0] <= lane_init(ang_s);
      for (int k = 1; k < 7; k++) begin
        stg[k] <= stg[k-1];
      end
      for (int l = 0; l < 2; l++) begin
        stg[1].ln[l].x2 <= 17'((34'(stg[0].ln[l].x) * 34'(stg[0].ln[l].x)) >> 16);
        stg[2].ln[l].p  <= poly_step(POLY_D, POLY_E, stg[1].ln[l].x2);
        stg[3].ln[l].p  <= poly_step(POLY_C, stg[2].ln[l].p, stg[2].ln[l].x2);
        stg[4].ln[l].p  <= poly_step(POLY_B, stg[3].ln[l].p, stg[3].ln[l].x2);
        stg[5].ln[l].p  <= poly_step(POLY_A, stg[4].ln[l].p, stg[4].ln[l].x2);
        stg[6].ln[l].c  <= round_q15(stg[5].ln[l].p, stg[5].ln[l].x, stg[5].ln[l].neg);
      end
      term.cos_term <= TERM_W'($signed({1'b0, stg[6].w}) * stg[6].ln[1].c);
      term.sin_term <= TERM_W'($signed({1'b0, stg[6].w}) * stg[6].ln[0].c);
      term.weight   <= stg[6].w;
      term.last     <= stg[6].last;
    end
  end

endmodule

/* rtl/core/bfa_queue.sv */
module bfa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  bfa_pkg::q_item_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output bfa_pkg::q_item_t rd_data
);
  import bfa_pkg::*;

  q_item_t         mem [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

/* rtl/core/bfa_back.sv */
module bfa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  bfa_pkg::q_item_t   q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bfa_pkg::out_item_t out_data
);
  import bfa_pkg::*;

  bk_state_t state;
  bk_state_t state_next;

  logic [SUM_W-1:0]  cos_sum;
  logic [SUM_W-1:0]  sin_sum;
  logic [WSUM_W-1:0] weight_sum;
  logic [SUM_W-1:0]  cm;
  logic [SUM_W-1:0]  sm;
  logic [95:0]       macc;
  logic [97:0]       xs;
  logic [50:0]       rem;
  logic [48:0]       root;
  logic [48:0]       drem;
  logic [48:0]       dv;
  logic [17:0]       quo;
  logic [5:0]        cnt;
  logic              r_zw;

  logic [SUM_W-1:0] opnd;
  logic [23:0]      ma;
  logic [23:0]      mb;
  logic [47:0]      pp;
  logic [95:0]      pp_sh;
  logic [50:0]      rem_sh;
  logic [50:0]      trial;
  logic             pop;

  assign q_ready = (state == BK_ACC);
  assign pop     = q_valid && q_ready;

  // one 24x24 partial product a cycle for cm^2 + sm^2
  always_comb begin
    opnd = cnt[2] ? sm : cm;
    ma   = cnt[1] ? opnd[47:24] : opnd[23:0];
    mb   = cnt[0] ? opnd[47:24] : opnd[23:0];
    pp   = ma * mb;
    case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0:    pp_sh = {48'b0, pp};
      2'd1:    pp_sh = {24'b0, pp, 24'b0};
      default: pp_sh = {pp, 48'b0};
    endcase
  end

  assign rem_sh = {rem[48:0], xs[97:96]};
  assign trial  = {root[48:0], 2'b01};

  always_comb begin
    state_next = state;
    case (state)
      BK_ACC:  if (pop && q_data.last) state_next = BK_LOAD;
      BK_LOAD: state_next = (weight_sum == '0) ? BK_DONE : BK_MUL;
      BK_MUL:  if (cnt[2:0] == 3'd7) state_next = BK_SQRT;
      BK_SQRT: if (cnt == '0) state_next = BK_DIV;
      BK_DIV:  if (cnt == '0) state_next = BK_DONE;
      BK_DONE: if (!out_valid || out_ready) state_next = BK_ACC;
      default: state_next = BK_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_ACC;
      cos_sum    <= '0;
      sin_sum    <= '0;
      weight_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (pop) begin
        cos_sum    <= cos_sum + {{(SUM_W-TERM_W){q_data.cos_term[TERM_W-1]}}, q_data.cos_term};
        sin_sum    <= sin_sum + {{(SUM_W-TERM_W){q_data.sin_term[TERM_W-1]}}, q_data.sin_term};
        weight_sum <= weight_sum + WSUM_W'(q_data.weight);
      end
      if (state == BK_LOAD) begin
        cos_sum    <= '0;
        sin_sum    <= '0;
        weight_sum <= '0;
      end
      if (state == BK_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_LOAD: begin
        cm    <= cos_sum[SUM_W-1] ? (SUM_W'(0) - cos_sum) : cos_sum;
        sm    <= sin_sum[SUM_W-1] ? (SUM_W'(0) - sin_sum) : sin_sum;
        dv    <= {weight_sum, 17'b0};
        macc  <= '0;
        cnt   <= '0;
        r_zw  <= (weight_sum == '0);
      end
      BK_MUL: begin
        macc <= macc + pp_sh;
        cnt  <= cnt + 1'b1;
        if (cnt[2:0] == 3'd7) begin
          xs   <= {macc + pp_sh, 2'b00};
          rem  <= '0;
          root <= '0;
          cnt  <= 6'd48;
        end
      end
      BK_SQRT: begin
        xs <= {xs[95:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[47:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[47:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          quo <= '0;
          cnt <= 6'd17;
          if (rem_sh >= trial) begin
            drem <= {root[47:0], 1'b1};
          end else begin
            drem <= {root[47:0], 1'b0};
          end
        end
      end
      BK_DIV: begin
        if (drem >= dv) begin
          drem <= drem - dv;
          quo  <= {quo[16:0], 1'b1};
        end else begin
          quo  <= {quo[16:0], 1'b0};
        end
        dv  <= dv >> 1;
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  // result register, loaded as the sequencer leaves its final state
  always_ff @(posedge clk) begin
    if (state == BK_DONE && (!out_valid || out_ready)) begin
      out_data.zero_weight <= r_zw;
      out_data.bunching    <= r_zw ? 17'd0 : ((quo > 18'(ONE_Q16)) ? ONE_Q16 : quo[16:0]);
    end
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  // expected slice results and the running sums that produce them
  class bunching_scoreboard;
    logic [47:0]  cos_acc;
    logic [47:0]  sin_acc;
    logic [31:0]  wt_acc;
    out_item_t    slice_results[$];
    int unsigned  mismatches;

    function new();
      cos_acc = '0;
      sin_acc = '0;
      wt_acc = '0;
      mismatches = 0;
    endfunction

    // sine of a 32-bit turn angle in q1.15, polynomial as the block uses it
    function int sine_q15(logic [31:0] ang);
      logic [1:0]      quad;
      longint unsigned x, x2, p, v;
      quad = ang[31:30];
      x = longint'(ang[29:14]);
      if (quad[0]) x = 65536 - x;
      x2 = (x * x) >> 16;
      p = POLY_E;
      p = POLY_D - ((p * x2) >> 16);
      p = POLY_C - ((p * x2) >> 16);
      p = POLY_B - ((p * x2) >> 16);
      p = POLY_A - ((p * x2) >> 16);
      v = (p * x) >> 16;
      v = (v + 16384) >> 15;
      if (v > 32768) v = 32768;
      return quad[1] ? -int'(v) : int'(v);
    endfunction

    function logic [47:0] add_weighted(logic [47:0] acc, logic [15:0] w, int s);
      logic [47:0] mag;
      mag = 48'(w) * 48'(s < 0 ? -s : s);
      return (s < 0) ? acc - mag : acc + mag;
    endfunction

    function logic [47:0] abs48(logic [47:0] v);
      return v[47] ? -v : v;
    endfunction

    // bit-serial search for floor(2*sqrt(c^2+s^2)/w), clamped to one
    function logic [16:0] ratio_q16();
      logic [127:0] four_m, t, c, s;
      logic [16:0]  r, cand;
      c = 128'(abs48(cos_acc));
      s = 128'(abs48(sin_acc));
      four_m = (c * c + s * s) << 2;
      r = '0;
      for (int b = 16; b >= 0; b--) begin
        cand = r | (17'd1 << b);
        if (cand > ONE_Q16) continue;
        t = 128'(cand) * 128'(wt_acc);
        if (t * t <= four_m) r = cand;
      end
      return r;
    endfunction

    function void note_particle(in_item_t it);
      logic [31:0] ang;
      out_item_t   res;
      ang = {it.phase, 16'd0};
      cos_acc = add_weighted(cos_acc, it.weight, sine_q15(ang + 32'h4000_0000));
      sin_acc = add_weighted(sin_acc, it.weight, sine_q15(ang));
      wt_acc = wt_acc + 32'(it.weight);
      if (!it.last) return;
      if (wt_acc == 0) begin
        res.bunching = '0;
        res.zero_weight = 1'b1;
      end else begin
        res.bunching = ratio_q16();
        res.zero_weight = 1'b0;
      end
      slice_results.push_back(res);
      cos_acc = '0;
      sin_acc = '0;
      wt_acc = '0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (slice_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result bunching=%0d zero_weight=%0b",
                   got.bunching, got.zero_weight);
        return;
      end
      want = slice_results.pop_front();
      if (got.bunching !== want.bunching || got.zero_weight !== want.zero_weight) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: bunching exp %0d got %0d, zero_weight exp %0b got %0b",
                   want.bunching, got.bunching, want.zero_weight, got.zero_weight);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 600000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  bunching_scoreboard sb;
  bit          idling_on;
  bit          hold_req;
  int unsigned cycles;
  int unsigned sent;

  bunching_factor_accumulator_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL bunching_factor_accumulator_top");
      $finish;
    end
  end

  // result side: every transaction taken is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver back-pressure: random short stalls plus long holds so the queue fills
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one particle, holding valid until the transaction is taken
  task automatic send_particle(logic [15:0] ph, logic [15:0] w, logic lst);
    in_item_t it;
    it.phase = ph;
    it.weight = w;
    it.last = lst;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_particle(it);
    sent = sent + 1;
  endtask

  // random slice; phases gathered round a centre by a random spread so the
  // bunching factor covers the whole range from near 0 to 1
  task automatic random_slice();
    int unsigned len, spread_bits;
    logic [15:0] centre, ph, w;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    centre = 16'($urandom);
    spread_bits = $urandom_range(0, 16);
    for (int i = 0; i < len; i++) begin
      ph = centre + 16'(($urandom & ((32'd1 << spread_bits) - 1)));
      case ($urandom_range(0, 7))
        0: w = 16'd0;
        1: w = 16'hFFFF;
        2: w = 16'($urandom_range(1, 15));
        default: w = 16'($urandom);
      endcase
      if ($urandom_range(0, 40) == 0) ph = 16'($urandom);
      send_particle(ph, w, i == len - 1);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    idling_on = 1'b1;
    hold_req = 1'b0;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single particles at the quadrant points and phase extremes
    send_particle(16'h0000, 16'hFFFF, 1'b1);
    send_particle(16'h4000, 16'hFFFF, 1'b1);
    send_particle(16'h8000, 16'h0001, 1'b1);
    send_particle(16'hC000, 16'hFFFF, 1'b1);
    send_particle(16'hFFFF, 16'h1234, 1'b1);
    send_particle(16'h0001, 16'hFFFF, 1'b1);
    // zero total weight, alone and over two particles
    send_particle(16'h2345, 16'h0000, 1'b1);
    send_particle(16'h0000, 16'h0000, 1'b0);
    send_particle(16'hFFFF, 16'h0000, 1'b1);
    // opposite phases cancel to nearly zero
    send_particle(16'h0000, 16'hFFFF, 1'b0);
    send_particle(16'h8000, 16'hFFFF, 1'b1);
    // four quadrants with equal weight
    send_particle(16'h0000, 16'h0100, 1'b0);
    send_particle(16'h4000, 16'h0100, 1'b0);
    send_particle(16'h8000, 16'h0100, 1'b0);
    send_particle(16'hC000, 16'h0100, 1'b1);
    // partly bunched, weight zero on the last particle
    send_particle(16'h1000, 16'h8000, 1'b0);
    send_particle(16'h3000, 16'h7FFF, 1'b0);
    send_particle(16'h5555, 16'h0000, 1'b1);
    // alternating bit patterns
    send_particle(16'hAAAA, 16'h5555, 1'b0);
    send_particle(16'h5555, 16'hAAAA, 1'b1);

    // random slices; long receiver holds early on, no idling near the end
    while (sent < 1400) begin
      if (sent >= 300 && sent < 350) hold_req = 1'b1;
      if (sent > 1200) idling_on = 1'b0;
      random_slice();
    end
    in_valid <= 1'b0;

    while (sb.slice_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASS bunching_factor_accumulator_top");
    else
      $display("FAIL bunching_factor_accumulator_top");
    $finish;
  end

endmodule
